// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ptds_pkg.sv =====
package ptds_pkg;

  // Fixed field widths of the request and result channels.
  localparam int TIME_W    = 32;
  localparam int KIND_W    = 2;
  localparam int IDX_OUT_W = 6;

  // Request kinds. The remaining code is ignored by the block.
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN   = 2'd2;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // One result as held in the output register.
  typedef struct packed {
    logic                 accepted;
    logic [IDX_OUT_W-1:0] task_index;
    logic                 run_task;
    logic                 last;
  } result_t;

  // Control strobes from the sequencer to the task table.
  typedef struct packed {
    logic add_we;
    logic run_we;
    logic rd_en;
  } tbl_ctl_t;

endpackage

// ===== rtl/core/ptds_req_if.sv =====
interface ptds_req_if;
  import ptds_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TIME_W-1:0] now_ms;
  logic [TIME_W-1:0] period_ms;
  logic              handler_present;

  modport source (output valid, kind, now_ms, period_ms, handler_present, input ready);
  modport sink   (input valid, kind, now_ms, period_ms, handler_present, output ready);
endinterface

// ===== rtl/core/ptds_rsp_if.sv =====
interface ptds_rsp_if;
  import ptds_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic [IDX_OUT_W-1:0] task_index;
  logic                 run_task;
  logic                 last;

  modport source (output valid, accepted, task_index, run_task, last, input ready);
  modport sink   (input valid, accepted, task_index, run_task, last, output ready);
endinterface

// ===== rtl/core/periodic_task_due_scanner.sv =====
// Channel  Dir  Carries
// req      in   kind, now_ms, period_ms, handler_present
// rsp      out  accepted, task_index, run_task, last
//
// Clear and add requests take one cycle and give their result the cycle after.
// A run request reads the table memory one entry per cycle while the scan does not stall;
// the registered read and the closing result follow the last entry read.
// Reset clears the task count and the sequencer; table contents are left as they are.
// A due task is held back one step so that the last flag can be set on the final one;
// the scan stalls while that held result waits for the output register.
`include "assert_macros.svh"

module periodic_task_due_scanner #(
  parameter int MAX_ENTRIES = 20
) (
  input logic      clk,
  input logic      rst,
  ptds_req_if.sink   req,
  ptds_rsp_if.source rsp
);
  import ptds_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  state_t            state;
  logic [CNT_W-1:0]  task_count;
  logic [CNT_W-1:0]  issued;
  logic              rd_valid;
  logic [AW-1:0]     cmp_idx;
  logic              have_pend;
  logic [AW-1:0]     pend_idx;
  logic [TIME_W-1:0] now_q;
  logic              out_valid;
  result_t           out_q;

  logic              req_fire;
  logic              out_free;
  logic              add_ok;
  logic              issue_left;
  logic              due;
  logic              due_hit;
  logic              stall;
  tbl_ctl_t          tbl_ctl;
  logic [AW-1:0]     wr_addr;
  logic [TIME_W-1:0] wr_time;

  // Handshake and request decode.
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign req_fire  = req.valid && req.ready;
  assign add_ok    = (task_count < CNT_W'(MAX_ENTRIES)) && req.handler_present
                     && (req.period_ms != '0);

  // Scan control: one read issued per cycle unless the held result cannot move on.
  assign issue_left = (issued < task_count);
  assign due_hit    = rd_valid && due;
  assign stall      = due_hit && have_pend && !out_free;

  // Table port strobes and write address selection.
  always_comb begin
    tbl_ctl.add_we = req_fire && (req.kind == KIND_ADD) && add_ok;
    tbl_ctl.run_we = (state == ST_SCAN) && due_hit && !stall;
    tbl_ctl.rd_en  = (state == ST_SCAN) && issue_left && !stall;
    wr_addr        = tbl_ctl.add_we ? task_count[AW-1:0] : cmp_idx;
    wr_time        = tbl_ctl.add_we ? req.now_ms : now_q;
  end

  ptds_table #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk        (clk),
    .ctl        (tbl_ctl),
    .wr_addr    (wr_addr),
    .rd_addr    (issued[AW-1:0]),
    .add_period (req.period_ms),
    .wr_time    (wr_time),
    .now        (now_q),
    .due        (due)
  );

  // Sequencer, scan pipeline and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      task_count <= '0;
      issued     <= '0;
      rd_valid   <= 1'b0;
      have_pend  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            now_q <= req.now_ms;
            if (req.kind == KIND_CLEAR) begin
              task_count <= '0;
              out_valid  <= 1'b1;
              out_q      <= '{accepted: 1'b0, task_index: '0, run_task: 1'b0, last: 1'b1};
            end else if (req.kind == KIND_ADD) begin
              out_valid <= 1'b1;
              out_q     <= '{accepted: add_ok,
                             task_index: add_ok ? IDX_OUT_W'(task_count) : '0,
                             run_task: 1'b0, last: 1'b1};
              if (add_ok) begin
                task_count <= task_count + 1'b1;
              end
            end else if (req.kind == KIND_RUN) begin
              if (task_count == '0) begin
                out_valid <= 1'b1;
                out_q     <= '{accepted: 1'b0, task_index: '0, run_task: 1'b0, last: 1'b1};
              end else begin
                state     <= ST_SCAN;
                issued    <= '0;
                rd_valid  <= 1'b0;
                have_pend <= 1'b0;
              end
            end
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            rd_valid <= tbl_ctl.rd_en;
            if (tbl_ctl.rd_en) begin
              issued  <= issued + 1'b1;
              cmp_idx <= issued[AW-1:0];
            end
            if (due_hit) begin
              have_pend <= 1'b1;
              pend_idx  <= cmp_idx;
              if (have_pend) begin
                out_valid <= 1'b1;
                out_q     <= '{accepted: 1'b0, task_index: IDX_OUT_W'(pend_idx),
                               run_task: 1'b1, last: 1'b0};
              end
            end
            if (!issue_left && !rd_valid) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (have_pend) begin
              out_q <= '{accepted: 1'b0, task_index: IDX_OUT_W'(pend_idx),
                         run_task: 1'b1, last: 1'b1};
            end else begin
              out_q <= '{accepted: 1'b0, task_index: '0, run_task: 1'b0, last: 1'b1};
            end
            have_pend <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result channel.
  assign rsp.valid      = out_valid;
  assign rsp.accepted   = out_q.accepted;
  assign rsp.task_index = out_q.task_index;
  assign rsp.run_task   = out_q.run_task;
  assign rsp.last       = out_q.last;

  // Checks on the table bookkeeping and the held due result.
  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, task_count <= CNT_W'(MAX_ENTRIES), "task count beyond table depth")
  `ASSERT_IMPL(a_pend_idle, clk, rst, state == ST_IDLE, !have_pend && !rd_valid, "scan state left over in idle")
  `ASSERT_NEXT(a_scan_push, clk, rst, (state == ST_SCAN) && due_hit && have_pend && !stall, out_valid && out_q.run_task && !out_q.last, "held due result not released")

endmodule

// ===== rtl/core/ptds_table.sv =====
module ptds_table #(
  parameter int DEPTH = 20,
  parameter int AW    = 5
) (
  input  logic                       clk,
  input  ptds_pkg::tbl_ctl_t         ctl,
  input  logic [AW-1:0]              wr_addr,
  input  logic [AW-1:0]              rd_addr,
  input  logic [ptds_pkg::TIME_W-1:0] add_period,
  input  logic [ptds_pkg::TIME_W-1:0] wr_time,
  input  logic [ptds_pkg::TIME_W-1:0] now,
  output logic                       due
);
  import ptds_pkg::*;

  logic [TIME_W-1:0] period_mem [DEPTH];
  logic [TIME_W-1:0] last_mem   [DEPTH];
  logic [TIME_W-1:0] rd_period;
  logic [TIME_W-1:0] rd_last;
  logic [TIME_W-1:0] due_at;

  // Period is written only by an add; last-run time by an add or a due hit.
  always_ff @(posedge clk) begin
    if (ctl.add_we) begin
      period_mem[wr_addr] <= add_period;
    end
    if (ctl.add_we || ctl.run_we) begin
      last_mem[wr_addr] <= wr_time;
    end
  end

  // Registered read; the data holds while the read enable is low.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_period <= period_mem[rd_addr];
      rd_last   <= last_mem[rd_addr];
    end
  end

  // Due test with the sum wrapping at the word width.
  assign due_at = rd_period + rd_last;
  assign due    = (now >= due_at);

endmodule

// ===== tb/tb_periodic_task_due_scanner.sv =====
module tb_periodic_task_due_scanner;
  import ptds_pkg::*;

  localparam int MAX_ENTRIES = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // One request as offered on the request channel.
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] period_ms;
    logic              handler_present;
  } sched_req_t;

  // One row of the directed stimulus table.
  typedef struct {
    sched_req_t rq;
    int         reps;
    bit         typed;
    result_t    outcome;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ptds_req_if req_ch ();
  ptds_rsp_if rsp_ch ();

  periodic_task_due_scanner #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #1 clk = ~clk;

  // Shadow copy of the task table.
  logic [TIME_W-1:0] period_tbl [MAX_ENTRIES];
  logic [TIME_W-1:0] last_run_tbl [MAX_ENTRIES];
  int unsigned       task_cnt = 0;

  result_t   pending_outcomes [$];
  stim_row_t dir_rows [$];
  int        mismatches = 0;
  int        tx_idle_pct = 0;
  int        rx_stall_pct = 0;
  int        hold_left = 0;
  bit        long_hold_go = 1'b0;
  longint    cycles = 0;
  logic [TIME_W-1:0] clock_ms = 32'd0;

  function automatic result_t outcome(logic acc, logic [IDX_OUT_W-1:0] idx, logic run,
                                      logic fin);
    result_t o;
    o.accepted   = acc;
    o.task_index = idx;
    o.run_task   = run;
    o.last       = fin;
    return o;
  endfunction

  // Works out the results of one request and updates the shadow table.
  function automatic void schedule_outcome(input sched_req_t rq, output result_t outs [$]);
    logic [TIME_W-1:0] due_at;
    outs = {};
    case (rq.kind)
      KIND_CLEAR: begin
        task_cnt = 0;
        outs.push_back(outcome(1'b0, '0, 1'b0, 1'b1));
      end
      KIND_ADD: begin
        if (task_cnt >= MAX_ENTRIES || !rq.handler_present || rq.period_ms == '0) begin
          outs.push_back(outcome(1'b0, '0, 1'b0, 1'b1));
        end else begin
          period_tbl[task_cnt]   = rq.period_ms;
          last_run_tbl[task_cnt] = rq.now_ms;
          outs.push_back(outcome(1'b1, IDX_OUT_W'(task_cnt), 1'b0, 1'b1));
          task_cnt++;
        end
      end
      KIND_RUN: begin
        for (int i = 0; i < task_cnt; i++) begin
          // The sum wraps at 32 bits, so a wrapped sum is due at once.
          due_at = period_tbl[i] + last_run_tbl[i];
          if (rq.now_ms >= due_at) begin
            last_run_tbl[i] = rq.now_ms;
            outs.push_back(outcome(1'b0, IDX_OUT_W'(i), 1'b1, 1'b0));
          end
        end
        if (outs.size() == 0) begin
          outs.push_back(outcome(1'b0, '0, 1'b0, 1'b1));
        end else begin
          outs[outs.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] now_ms,
                                  logic [TIME_W-1:0] period_ms, logic handler, int reps,
                                  bit typed, result_t exp_outcome);
    stim_row_t row;
    row.rq.kind            = kind;
    row.rq.now_ms          = now_ms;
    row.rq.period_ms       = period_ms;
    row.rq.handler_present = handler;
    row.reps               = reps;
    row.typed              = typed;
    row.outcome            = exp_outcome;
    dir_rows.push_back(row);
  endfunction

  // Random request: mostly adds and runs on an advancing clock, some noise.
  function automatic sched_req_t random_request();
    sched_req_t rq;
    int         pick;
    int         sel;
    pick               = $urandom_range(0, 99);
    rq.now_ms          = $urandom;
    rq.period_ms       = $urandom;
    rq.handler_present = $urandom_range(0, 1);
    if (pick < 3) begin
      rq.kind = KIND_CLEAR;
    end else if (pick < 5) begin
      rq.kind = KIND_UNUSED;
    end else if (pick < 40) begin
      rq.kind            = KIND_ADD;
      rq.handler_present = ($urandom_range(0, 15) != 0);
      sel                = $urandom_range(0, 15);
      if (sel == 0) begin
        rq.period_ms = '0;
      end else if (sel > 1) begin
        rq.period_ms = $urandom_range(1, 300);
      end
      if ($urandom_range(0, 15) != 0) begin
        rq.now_ms = clock_ms;
      end
    end else begin
      rq.kind  = KIND_RUN;
      clock_ms = clock_ms + $urandom_range(0, 150);
      sel      = $urandom_range(0, 19);
      if (sel == 1) begin
        // Jump close to the top of the range so that sums wrap.
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
      end
      if (sel != 0) begin
        rq.now_ms = clock_ms;
      end
    end
    return rq;
  endfunction

  // Offers one request and records its expected results once accepted.
  task automatic send_request(input sched_req_t rq, input bit typed, input result_t typed_out);
    result_t outs [$];
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.kind            <= rq.kind;
    req_ch.now_ms          <= rq.now_ms;
    req_ch.period_ms       <= rq.period_ms;
    req_ch.handler_present <= rq.handler_present;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    schedule_outcome(rq, outs);
    if (typed) begin
      pending_outcomes.push_back(typed_out);
    end else begin
      foreach (outs[i]) pending_outcomes.push_back(outs[i]);
    end
  endtask

  task automatic send_random(input int count);
    sched_req_t rq;
    int         sent;
    sent = 0;
    while (sent < count) begin
      rq = random_request();
      send_request(rq, 1'b0, outcome(1'b0, '0, 1'b0, 1'b0));
      if (rq.kind != KIND_UNUSED) sent++;
    end
  endtask

  // Result side: random stalls, plus a long hold-off on demand.
  always @(posedge clk) begin
    if (long_hold_go) begin
      hold_left    = LONG_HOLD_CYCLES;
      long_hold_go = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = outcome(rsp_ch.accepted, rsp_ch.task_index, rsp_ch.run_task, rsp_ch.last);
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: accepted %0d task_index %0d run_task %0d last %0d",
                   got.accepted, got.task_index, got.run_task, got.last);
        end
      end else begin
        want = pending_outcomes.pop_front();
        if (got.accepted !== want.accepted || got.task_index !== want.task_index ||
            got.run_task !== want.run_task || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch (expected/actual): accepted %0d/%0d task_index %0d/%0d",
                     want.accepted, got.accepted, want.task_index, got.task_index);
            $display("  run_task %0d/%0d last %0d/%0d",
                     want.run_task, got.run_task, want.last, got.last);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    result_t done_only;
    done_only = outcome(1'b0, '0, 1'b0, 1'b1);

    req_ch.valid           = 1'b0;
    req_ch.kind            = KIND_CLEAR;
    req_ch.now_ms          = '0;
    req_ch.period_ms       = '0;
    req_ch.handler_present = 1'b0;
    rsp_ch.ready           = 1'b0;

    // Directed table: empty table, refusals, wrapping sums, a full table.
    add_row(KIND_RUN, 32'd0, 32'd0, 1'b0, 1, 1'b1, done_only);
    add_row(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1, 1'b1, done_only);
    add_row(KIND_ADD, 32'd7, 32'd5, 1'b0, 1, 1'b1, done_only);
    add_row(KIND_ADD, 32'd7, 32'd0, 1'b1, 1, 1'b1, done_only);
    add_row(KIND_ADD, 32'd0, 32'd1, 1'b1, 1, 1'b1, outcome(1'b1, 6'd0, 1'b0, 1'b1));
    add_row(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1, 1'b1,
            outcome(1'b1, 6'd1, 1'b0, 1'b1));
    add_row(KIND_ADD, 32'd100, 32'hFFFF_FFFF, 1'b1, 1, 1'b1,
            outcome(1'b1, 6'd2, 1'b0, 1'b1));
    add_row(KIND_ADD, 32'd1000, 32'd500, 1'b1, 1, 1'b1, outcome(1'b1, 6'd3, 1'b0, 1'b1));
    add_row(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1, 1'b0, done_only);
    add_row(KIND_RUN, 32'd0, 32'd0, 1'b0, 1, 1'b1, done_only);
    add_row(KIND_RUN, 32'd1499, 32'd0, 1'b0, 1, 1'b0, done_only);
    add_row(KIND_RUN, 32'hFFFF_FFFF, 32'd0, 1'b0, 1, 1'b0, done_only);
    add_row(KIND_ADD, 32'd5, 32'd10, 1'b1, MAX_ENTRIES - 4, 1'b0, done_only);
    add_row(KIND_ADD, 32'd5, 32'd10, 1'b1, 1, 1'b1, done_only);
    add_row(KIND_RUN, 32'h7FFF_FFFF, 32'd0, 1'b0, 1, 1'b0, done_only);
    add_row(KIND_RUN, 32'hFFFF_FFFF, 32'd0, 1'b0, 1, 1'b0, done_only);
    add_row(KIND_CLEAR, 32'd0, 32'd0, 1'b0, 1, 1'b1, done_only);
    add_row(KIND_RUN, 32'hFFFF_FFFF, 32'd0, 1'b0, 1, 1'b1, done_only);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps) begin
        send_request(dir_rows[r].rq, dir_rows[r].typed, dir_rows[r].outcome);
      end
    end

    // Random requests with no idling on either side.
    clock_ms = $urandom_range(0, 1000);
    send_random(100);

    // Result side held off while requests keep coming, then a full drain.
    long_hold_go = 1'b1;
    send_random(40);
    req_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);

    tx_idle_pct  = 82;
    rx_stall_pct = 0;
    send_random(120);

    tx_idle_pct  = 0;
    rx_stall_pct = 82;
    send_random(120);

    tx_idle_pct  = 16;
    rx_stall_pct = 16;
    send_random(120);

    req_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ptds_pkg.sv
rtl/core/ptds_req_if.sv
rtl/core/ptds_rsp_if.sv
rtl/core/ptds_table.sv
rtl/core/periodic_task_due_scanner.sv
tb/tb_periodic_task_due_scanner.sv
